// File: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the block buffer cache tag manager
// Request, scan carry and update word formats used along the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;

  localparam int SLOT_MAX_W = 10;   // enough for 1024 slots
  localparam int REFS_W     = 16;
  localparam int STAMP_W    = 32;
  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef logic [SLOT_MAX_W-1:0] slot_t;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_FETCH     = 3'd1;
  localparam logic [2:0] ST_ZERO      = 3'd2;
  localparam logic [2:0] ST_NOADDR    = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;
  localparam logic [2:0] ST_HELD      = 3'd5;
  localparam logic [2:0] ST_RELEASED  = 3'd6;
  localparam logic [2:0] ST_BADPUT    = 3'd7;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_FILL = 2'd2
  } upd_op_t;

  // request held steady while the scan wave runs down the chain
  typedef struct packed {
    logic        cmd;
    logic [31:0] inode;
    logic [31:0] index;
    logic [5:0]  rslot;
  } req_t;

  // running search results handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               hit;
    slot_t              hit_idx;
    logic               free;
    slot_t              free_idx;
    logic               cand;
    logic [STAMP_W-1:0] best_stamp;
    slot_t              best_idx;
    logic               sel_valid;
    logic [REFS_W-1:0]  sel_refs;
  } carry_t;

  typedef struct packed {
    logic               en;
    upd_op_t            op;
    slot_t              idx;
    logic [31:0]        inode;
    logic [31:0]        index;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

endpackage
`default_nettype wire

// File: rtl/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell: one buffer slot of the tag manager
// Holds the slot's tag, count and release stamp; folds itself into the
// search word passing by and applies updates addressed to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bbc_cell
  import bbc_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  wire    clk,
  input  wire    rst,
  input  req_t   req,
  input  upd_t   upd,
  input  carry_t cin,
  output carry_t cout
);

  localparam slot_t MY_ID = slot_t'(CELL_ID);

  logic               valid;
  logic [31:0]        tag_inode;
  logic [31:0]        tag_index;
  logic [REFS_W-1:0]  refs;
  logic [STAMP_W-1:0] stamp;
  carry_t             cout_next;
  logic               me;

  assign me = upd.en && (upd.idx == MY_ID);

  always_comb begin
    cout_next = cin;
    if (!cin.hit && valid && tag_inode == req.inode && tag_index == req.index) begin
      cout_next.hit     = 1'b1;
      cout_next.hit_idx = MY_ID;
    end
    if (!cin.free && !valid) begin
      cout_next.free     = 1'b1;
      cout_next.free_idx = MY_ID;
    end
    // strict less keeps the lowest slot on a tie
    if (valid && refs == '0 && (!cin.cand || stamp < cin.best_stamp)) begin
      cout_next.cand       = 1'b1;
      cout_next.best_stamp = stamp;
      cout_next.best_idx   = MY_ID;
    end
    if (MY_ID == slot_t'(req.rslot)) begin
      cout_next.sel_valid = valid;
      cout_next.sel_refs  = refs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= cin.vld ? cout_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      refs  <= '0;
      stamp <= '0;
    end else if (me) begin
      unique case (upd.op)
        OP_INC: begin
          if (refs != REFS_MAX) refs <= refs + REFS_W'(1);
        end
        OP_DEC: begin
          refs <= refs - REFS_W'(1);
          if (refs == REFS_W'(1)) stamp <= upd.stamp;
        end
        OP_FILL: begin
          valid <= 1'b1;
          refs  <= REFS_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (me && upd.op == OP_FILL) begin
      tag_inode <= upd.inode;
      tag_index <= upd.index;
    end
  end

endmodule
`default_nettype wire

// File: rtl/block_buffer_cache_lru.sv
// Flow: an accepted word is registered, the scan wave walks the slot chain
// one cell per cycle, the chain end is registered as the result, and the
// outputs load on commit; the next word is taken once the result is set.
// Reset: synchronous, clears all counts, stamps, fill flags and the release
// clock at once; no clearing pass.
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: reference-counted buffer cache tag manager
// Looks up, fills, and releases slots; victim is least recently released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module block_buffer_cache_lru
  import bbc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         command,
  input  wire  [31:0] inode,
  input  wire  [31:0] block_index,
  input  wire  [31:0] block_address,
  input  wire         address_valid,
  input  wire  [5:0]  release_slot,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  status,
  output logic [5:0]  slot,
  output logic [31:0] fetch_address,
  output logic        evicted
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state, state_next;
  req_t               req;
  logic [31:0]        req_addr;
  logic               req_avalid;
  logic               start;
  carry_t             res;
  logic [STAMP_W-1:0] release_clock;
  upd_t               upd;
  logic               commit;
  logic [2:0]         status_next;
  logic [5:0]         slot_next;
  logic [31:0]        fetch_next;
  logic               evicted_next;
  logic               clock_bump;
  carry_t             chain [ENTRIES+1];

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    chain[0]     = '0;
    chain[0].vld = start;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bbc_cell #(.CELL_ID(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .req  (req),
      .upd  (upd),
      .cin  (chain[g]),
      .cout (chain[g+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (chain[ENTRIES].vld) state_next = S_DONE;
      S_DONE: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // result and slot update
  always_comb begin
    status_next  = ST_BADPUT;
    slot_next    = req.rslot;
    fetch_next   = '0;
    evicted_next = 1'b0;
    clock_bump   = 1'b0;
    upd          = '0;
    upd.op       = OP_INC;
    upd.inode    = req.inode;
    upd.index    = req.index;
    upd.stamp    = release_clock;
    if (req.cmd == CMD_PUT) begin
      if (res.sel_valid && res.sel_refs != '0) begin
        upd.en  = commit;
        upd.op  = OP_DEC;
        upd.idx = slot_t'(req.rslot);
        if (res.sel_refs == REFS_W'(1)) begin
          status_next = ST_RELEASED;
          clock_bump  = 1'b1;
        end else begin
          status_next = ST_HELD;
        end
      end
    end else begin
      slot_next = '0;
      priority if (res.hit) begin
        status_next = ST_HIT;
        slot_next   = res.hit_idx[5:0];
        upd.en      = commit;
        upd.op      = OP_INC;
        upd.idx     = res.hit_idx;
      end else if (!req_avalid) begin
        status_next = ST_NOADDR;
      end else if (req_addr == '0) begin
        status_next = ST_ZERO;
      end else if (res.free || res.cand) begin
        status_next  = ST_FETCH;
        fetch_next   = req_addr;
        evicted_next = !res.free;
        upd.en       = commit;
        upd.op       = OP_FILL;
        upd.idx      = res.free ? res.free_idx : res.best_idx;
        slot_next    = upd.idx[5:0];
      end else begin
        status_next = ST_EXHAUSTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      start         <= 1'b0;
      out_valid     <= 1'b0;
      release_clock <= '0;
    end else begin
      state <= state_next;
      start <= in_valid && in_ready;
      if (commit) begin
        out_valid <= 1'b1;
        if (clock_bump) release_clock <= release_clock + STAMP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.cmd    <= command;
      req.inode  <= inode;
      req.index  <= block_index;
      req.rslot  <= release_slot;
      req_addr   <= block_address;
      req_avalid <= address_valid;
    end
    if (state == S_SCAN && chain[ENTRIES].vld) res <= chain[ENTRIES];
    if (commit) begin
      status        <= status_next;
      slot          <= slot_next;
      fetch_address <= fetch_next;
      evicted       <= evicted_next;
    end
  end

endmodule
`default_nettype wire
